// ===== rtl/core/tet_pkg.sv =====
// ----------------------------------------------------------------------------
// token expiry table package
// shared sizes, operation codes and status codes
// ----------------------------------------------------------------------------
package tet_pkg;

    // table geometry
    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

    // field widths
    localparam int KEY_W  = 64;
    localparam int TIME_W = 32;
    localparam int EXP_W  = TIME_W + 1;
    localparam int SEQ_W  = 32;
    localparam int TTL_W  = 16;
    localparam int LIVE_W = 7;

    localparam logic [TTL_W-1:0]  TTL_RESET = 16'd5;
    localparam logic [LIVE_W-1:0] LIVE_MAX  = 7'd127;

    // operation codes
    localparam logic [1:0] KIND_GENERATE = 2'd0;
    localparam logic [1:0] KIND_RENEW    = 2'd1;
    localparam logic [1:0] KIND_COUNT    = 2'd2;

    // status codes
    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_FULL = 2'd1;
    localparam logic [1:0] STATUS_MISS = 2'd2;

endpackage

// ===== rtl/core/token_expiry_table_top.sv =====
// ----------------------------------------------------------------------------
// token expiry table
// 64-slot table of keys with expiry times; generate, renew, count and purge
// ----------------------------------------------------------------------------
// one item is in progress at a time: the scan reads slots 0 .. N-1 through the
//   single table read port into the one slot compare unit, one slot a cycle
// the next item is taken once the last one commits, while that finished result
//   may still wait at the output
// reset (synchronous, active low) clears all valid bits at once, the
//   sequence counter and the lifetime register (back to 5); no clearing pass
module token_expiry_table_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration
    input  logic                        i_cfg_we,
    input  logic [tet_pkg::TTL_W-1:0]   i_cfg_data,
    // input items
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [1:0]                  i_kind,
    input  logic [tet_pkg::KEY_W-1:0]   i_token_key,
    input  logic [tet_pkg::TIME_W-1:0]  i_current_time,
    // result items
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [tet_pkg::LIVE_W-1:0]  o_live_count,
    output logic [1:0]                  o_status
);

    localparam int N = tet_pkg::TABLE_ENTRIES;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_COMMIT = 4'b0100,
        S_HOLD   = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [tet_pkg::TTL_W-1:0]  r_ttl;

    // captured item
    logic [1:0]                 r_kind;
    logic [tet_pkg::KEY_W-1:0]  r_key;
    logic [tet_pkg::TIME_W-1:0] r_now;

    // table storage: valid bits in flops, the rest in memory
    logic [N-1:0]               r_slot_valid;
    logic [tet_pkg::KEY_W-1:0]  r_mem_key [N];
    logic [tet_pkg::EXP_W-1:0]  r_mem_exp [N];
    logic [tet_pkg::SEQ_W-1:0]  r_mem_seq [N];
    logic [tet_pkg::SEQ_W-1:0]  r_next_seq;

    // scan pipeline: read issue, then compare in the following cycle
    logic [tet_pkg::CNT_W-1:0]  r_rd_cnt;
    logic [tet_pkg::IDX_W-1:0]  rd_addr;
    logic                       rd_issue;
    logic                       r_cmp_vld;
    logic [tet_pkg::IDX_W-1:0]  r_cmp_idx;
    logic [tet_pkg::KEY_W-1:0]  r_rd_key;
    logic [tet_pkg::EXP_W-1:0]  r_rd_exp;
    logic [tet_pkg::SEQ_W-1:0]  r_rd_seq;

    // scan results
    logic                       r_found;
    logic [tet_pkg::IDX_W-1:0]  r_sel_idx;
    logic [tet_pkg::SEQ_W-1:0]  r_best_seq;
    logic [tet_pkg::LIVE_W-1:0] r_count;

    // output register
    logic                       r_out_valid;
    logic [tet_pkg::LIVE_W-1:0] r_live_count;
    logic [1:0]                 r_status;

    logic                       in_accept;
    logic                       out_free;
    logic                       commit_go;
    logic                       slot_valid;
    logic                       slot_live;
    logic                       key_hit;
    logic                       seq_newer;
    logic                       scan_done;
    logic [tet_pkg::EXP_W-1:0]  new_exp;
    logic                       wr_gen;
    logic                       wr_renew;

    assign in_accept = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free  = !r_out_valid || !i_out_stall;
    assign commit_go = (r_state == S_COMMIT) && out_free;

    // read addresses run 0 .. N-1, the counter reaching N ends issuing
    assign rd_issue  = (r_state == S_SCAN) && (r_rd_cnt != tet_pkg::CNT_W'(N));
    assign rd_addr   = rd_issue ? r_rd_cnt[tet_pkg::IDX_W-1:0] : '0;
    assign scan_done = (r_state == S_SCAN) && !rd_issue && !r_cmp_vld;

    // the shared slot compare unit
    assign slot_valid = r_slot_valid[r_cmp_idx];
    assign slot_live  = slot_valid && (r_rd_exp > {1'b0, r_now});
    assign key_hit    = (r_rd_key == r_key);
    assign seq_newer  = !r_found || (r_rd_seq > r_best_seq);

    assign new_exp  = {1'b0, r_now} + {{(tet_pkg::EXP_W-tet_pkg::TTL_W){1'b0}}, r_ttl};
    assign wr_gen   = commit_go && (r_kind == tet_pkg::KIND_GENERATE) && r_found;
    assign wr_renew = commit_go && (r_kind == tet_pkg::KIND_RENEW) && r_found;

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (in_accept) n_state = S_SCAN;
            S_SCAN:   if (scan_done) n_state = S_COMMIT;
            S_COMMIT: if (out_free) n_state = S_IDLE;
            S_HOLD:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // lifetime register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ttl <= tet_pkg::TTL_RESET;
        end else if (i_cfg_we) begin
            r_ttl <= i_cfg_data;
        end
    end

    // item capture
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_kind <= i_kind;
            r_key  <= i_token_key;
            r_now  <= i_current_time;
        end
    end

    // scan counter and compare stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_cnt  <= '0;
            r_cmp_vld <= 1'b0;
        end else begin
            if (in_accept) begin
                r_rd_cnt <= '0;
            end else if (rd_issue) begin
                r_rd_cnt <= r_rd_cnt + 1'b1;
            end
            r_cmp_vld <= rd_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx <= rd_addr;
    end

    // table memory: one write port, one registered read port per field
    always_ff @(posedge i_clk) begin
        if (wr_gen) begin
            r_mem_key[r_sel_idx] <= r_key;
            r_mem_seq[r_sel_idx] <= r_next_seq;
        end
        if (wr_gen || wr_renew) begin
            r_mem_exp[r_sel_idx] <= new_exp;
        end
        r_rd_key <= r_mem_key[rd_addr];
        r_rd_exp <= r_mem_exp[rd_addr];
        r_rd_seq <= r_mem_seq[rd_addr];
    end

    // per-slot decisions during the scan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
            r_count <= '0;
        end else if (in_accept) begin
            r_found <= 1'b0;
            r_count <= '0;
        end else if (r_cmp_vld) begin
            case (r_kind)
                tet_pkg::KIND_GENERATE: begin
                    // lowest slot that is free or expired
                    if (!slot_live && !r_found) begin
                        r_found   <= 1'b1;
                        r_sel_idx <= r_cmp_idx;
                    end
                end
                tet_pkg::KIND_RENEW: begin
                    // newest live match, ties keep the lower slot
                    if (slot_live && key_hit && seq_newer) begin
                        r_found    <= 1'b1;
                        r_sel_idx  <= r_cmp_idx;
                        r_best_seq <= r_rd_seq;
                    end
                end
                tet_pkg::KIND_COUNT: begin
                    if (slot_live && (r_count != tet_pkg::LIVE_MAX)) begin
                        r_count <= r_count + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // valid bits: purge on count, set on a stored generate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_valid <= '0;
        end else begin
            if (r_cmp_vld && (r_kind == tet_pkg::KIND_COUNT) && slot_valid && !slot_live) begin
                r_slot_valid[r_cmp_idx] <= 1'b0;
            end
            if (wr_gen) begin
                r_slot_valid[r_sel_idx] <= 1'b1;
            end
        end
    end

    // insertion sequence number
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_seq <= '0;
        end else if (wr_gen) begin
            r_next_seq <= r_next_seq + 1'b1;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit_go) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit_go) begin
            r_live_count <= '0;
            r_status     <= tet_pkg::STATUS_OK;
            case (r_kind)
                tet_pkg::KIND_GENERATE: begin
                    if (!r_found) r_status <= tet_pkg::STATUS_FULL;
                end
                tet_pkg::KIND_RENEW: begin
                    if (!r_found) r_status <= tet_pkg::STATUS_MISS;
                end
                tet_pkg::KIND_COUNT: begin
                    r_live_count <= r_count;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_live_count = r_live_count;
    assign o_status     = r_status;

    // checks
    a_commit_gives_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit_go |=> o_out_valid)
        else $error("commit did not present an item");

    a_count_only_on_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_live_count != '0)) |-> (o_status == tet_pkg::STATUS_OK))
        else $error("live count with non-ok status");

    a_seq_moves_on_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !wr_gen |=> $stable(r_next_seq))
        else $error("sequence moved without a stored generate");

    a_scan_never_adds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |=>
            ($countones(r_slot_valid) <= $past($countones(r_slot_valid))))
        else $error("valid slot appeared during scan");

    a_stall_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cmp_vld || (r_state == S_COMMIT)) |-> o_in_stall)
        else $error("input open while an item is in progress");

endmodule
